/* design/bsd_pkg.sv */
// ============================================================================
// Byte stuffing deframer package
// Shared word types, configuration bundle, status codes and register indexes.
// ============================================================================
package bsd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_BREAK_VALUE     = 3'd0;
    localparam logic [2:0] CFG_ESCAPE_VALUE    = 3'd1;
    localparam logic [2:0] CFG_CODE_FOR_BREAK  = 3'd2;
    localparam logic [2:0] CFG_CODE_FOR_ESCAPE = 3'd3;
    localparam logic [2:0] CFG_MAX_LENGTH      = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_BREAK_VALUE     = 8'd126;
    localparam logic [7:0]  RST_ESCAPE_VALUE    = 8'd125;
    localparam logic [7:0]  RST_CODE_FOR_BREAK  = 8'd94;
    localparam logic [7:0]  RST_CODE_FOR_ESCAPE = 8'd93;
    localparam logic [15:0] RST_MAX_LENGTH      = 16'd2048;

    // Result status codes.
    localparam logic [2:0] ST_DATA      = 3'd0;
    localparam logic [2:0] ST_CLOSED    = 3'd1;
    localparam logic [2:0] ST_ENDED     = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_TRAIL_ESC = 3'd4;
    localparam logic [2:0] ST_BAD_ESC   = 3'd5;

    // Depth of the result queue; it must hold at least two words.
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] raw_byte;
        logic       end_of_input;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  decoded_byte;
        logic [15:0] frame_length;
        logic [2:0]  status;
        logic        last;
    } out_word_t;

    typedef struct packed {
        logic [7:0]  break_value;
        logic [7:0]  escape_value;
        logic [7:0]  code_for_break;
        logic [7:0]  code_for_escape;
        logic [15:0] max_length;
    } cfg_t;

    // Results produced by one input word: zero, one or two of them.
    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } push_t;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'b001,
        PH_FRAME = 3'b010,
        PH_SKIP  = 3'b100
    } phase_t;

endpackage

/* design/bsd_cfg_regs.sv */
// ============================================================================
// Byte stuffing deframer configuration registers
// Holds the break, escape and code values and the frame capacity.
// ============================================================================
module bsd_cfg_regs
    import bsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.break_value     <= RST_BREAK_VALUE;
            cfg_reg.escape_value    <= RST_ESCAPE_VALUE;
            cfg_reg.code_for_break  <= RST_CODE_FOR_BREAK;
            cfg_reg.code_for_escape <= RST_CODE_FOR_ESCAPE;
            cfg_reg.max_length      <= RST_MAX_LENGTH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BREAK_VALUE:     cfg_reg.break_value     <= cfg_data[7:0];
                CFG_ESCAPE_VALUE:    cfg_reg.escape_value    <= cfg_data[7:0];
                CFG_CODE_FOR_BREAK:  cfg_reg.code_for_break  <= cfg_data[7:0];
                CFG_CODE_FOR_ESCAPE: cfg_reg.code_for_escape <= cfg_data[7:0];
                CFG_MAX_LENGTH:      cfg_reg.max_length      <= cfg_data;
                default:             ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/bsd_decoder.sv */
// ============================================================================
// Byte stuffing deframer decoder
// Tracks frame phase, pending escape and byte count; emits up to two results.
// ============================================================================
module bsd_decoder
    import bsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     accept,
    input  in_word_t in_word,
    output push_t    push
);

    phase_t      phase_reg, phase_next;
    logic        esc_pending_reg, esc_pending_next;
    logic [15:0] byte_count_reg, byte_count_next;

    logic        finish_en;
    logic [2:0]  finish_status;
    logic        store_en;
    logic [7:0]  store_byte;
    logic [15:0] count_inc;
    logic        eoi;
    logic [7:0]  b;

    assign b         = in_word.raw_byte;
    assign eoi       = in_word.end_of_input;
    assign count_inc = byte_count_reg + 16'd1;

    always_comb
    begin
        phase_next       = phase_reg;
        esc_pending_next = esc_pending_reg;
        byte_count_next  = byte_count_reg;
        finish_en        = 1'b0;
        finish_status    = ST_ENDED;
        store_en         = 1'b0;
        store_byte       = b;
        push             = '0;

        if (accept)
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (eoi)
                        phase_next = PH_HUNT;
                end
                PH_FRAME:
                begin
                    if (esc_pending_reg)
                    begin
                        esc_pending_next = 1'b0;
                        priority if (b == cfg.code_for_break)
                        begin
                            store_en   = 1'b1;
                            store_byte = cfg.break_value;
                        end
                        else if (b == cfg.code_for_escape)
                        begin
                            store_en   = 1'b1;
                            store_byte = cfg.escape_value;
                        end
                        else
                        begin
                            finish_en     = 1'b1;
                            finish_status = ST_BAD_ESC;
                        end
                    end
                    else
                    begin
                        priority if (b == cfg.break_value)
                        begin
                            finish_en     = 1'b1;
                            finish_status = ST_CLOSED;
                        end
                        else if (b == cfg.escape_value)
                        begin
                            if (eoi)
                            begin
                                finish_en     = 1'b1;
                                finish_status = ST_TRAIL_ESC;
                            end
                            else
                                esc_pending_next = 1'b1;
                        end
                        else
                            store_en = 1'b1;
                    end
                end
                default:
                begin
                    if (b == cfg.break_value)
                    begin
                        phase_next       = PH_FRAME;
                        esc_pending_next = 1'b0;
                        byte_count_next  = '0;
                        if (eoi)
                        begin
                            finish_en     = 1'b1;
                            finish_status = ST_ENDED;
                        end
                    end
                end
            endcase

            // A stored byte that would exceed the capacity ends the frame instead.
            if (store_en)
            begin
                if (byte_count_reg >= cfg.max_length)
                begin
                    finish_en     = 1'b1;
                    finish_status = ST_OVERFLOW;
                end
                else
                begin
                    byte_count_next           = count_inc;
                    push.count                = 2'd1;
                    push.first.decoded_byte   = store_byte;
                    push.first.frame_length   = count_inc;
                    push.first.status         = ST_DATA;
                    push.first.last           = 1'b0;
                    if (eoi)
                    begin
                        push.count                = 2'd2;
                        push.second.decoded_byte  = '0;
                        push.second.frame_length  = count_inc;
                        push.second.status        = ST_ENDED;
                        push.second.last          = 1'b1;
                        esc_pending_next          = 1'b0;
                        phase_next                = PH_HUNT;
                    end
                end
            end

            // Status result; the count is the one held before this word, or zero for a break that opens a frame.
            if (finish_en)
            begin
                push.count              = 2'd1;
                push.first.decoded_byte = '0;
                push.first.frame_length = byte_count_next;
                push.first.status       = finish_status;
                push.first.last         = 1'b1;
                esc_pending_next        = 1'b0;
                phase_next              = eoi ? PH_HUNT : PH_SKIP;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            esc_pending_reg <= 1'b0;
            byte_count_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            esc_pending_reg <= esc_pending_next;
            byte_count_reg  <= byte_count_next;
        end
    end

endmodule

/* design/bsd_out_queue.sv */
// ============================================================================
// Byte stuffing deframer result queue
// Small register queue taking up to two words per cycle and giving one unless stalled.
// ============================================================================
module bsd_out_queue
    import bsd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    output logic      full,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    out_word_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0]     head_reg, head_next;
    logic [QPTR_W-1:0]     tail_reg, tail_next;
    logic [QCOUNT_W-1:0]   count_reg, count_next;
    logic                  pop;
    logic [QPTR_W-1:0]     tail_plus1;

    assign out_valid  = (count_reg != '0);
    assign out_word   = mem_reg[head_reg];
    assign pop        = out_valid && !out_stall;
    assign tail_plus1 = tail_reg + QPTR_W'(1);

    // Room for two words is needed before a new input word is taken.
    assign full = (count_reg > QCOUNT_W'(QDEPTH - 2));

    always_comb
    begin
        head_next  = pop ? head_reg + QPTR_W'(1) : head_reg;
        tail_next  = tail_reg + QPTR_W'(push.count);
        count_next = count_reg + QCOUNT_W'(push.count) - QCOUNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[tail_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[tail_plus1] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

/* design/byte_stuffing_deframer.sv */
// ============================================================================
// Byte stuffing deframer
// Recovers byte-stuffed frames from link bytes and reports how each one ends.
// ============================================================================
//
//   Channel   Signals                           Direction
//   input     in_valid, in_stall, in_data      link word in, stall out
//   output    out_valid, out_stall, out_data   result word out, stall in
//   config    cfg_we, cfg_index, cfg_data      register write in
//
// One input word is decoded in the cycle it is accepted and its results are
// written to a four-word queue, so a word can be taken every cycle unless in_stall is high.
// A data word on the last link byte yields two results; the queue drains one
// result per cycle while out_stall is low, which sets the sustained rate at one word per cycle.
// Results are registered in the queue and reach the output once older results are taken.
// Reset returns the configuration and decoder registers to their defaults and empties the queue.
// in_stall rises when the queue cannot take two more results.
module byte_stuffing_deframer
    import bsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_word_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_word_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg;
    push_t push;
    logic  accept;
    logic  full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    bsd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bsd_decoder u_decoder (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .accept  (accept),
        .in_word (in_data),
        .push    (push)
    );

    bsd_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_data)
    );

endmodule

/* dv/tb_byte_stuffing_deframer.sv */
// ============================================================================
// Byte stuffing deframer testbench
// Sends link bytes grouped into received buffers: a few directed buffers
// first, then random ones that are mostly well-formed frames with random
// content, escape pairs, all five endings and some noise. The register set
// changes between phases, with extreme values among the settings. A small
// scoreboard decodes every accepted link word itself and checks each result
// word, field by field, against the oldest expected one. Both sides idle at
// random, and the receiver once holds off long enough to fill the block.
// ============================================================================
module tb_byte_stuffing_deframer;
    import bsd_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASE_WORDS     = 350;

    // Keeps its own copy of the registers and the decoder state, and the
    // result words that the accepted link words must cause, oldest first.
    class deframer_scoreboard;
        logic [7:0]  break_value;
        logic [7:0]  escape_value;
        logic [7:0]  code_for_break;
        logic [7:0]  code_for_escape;
        logic [15:0] max_length;
        phase_t      phase;
        logic        escape_pending;
        logic [15:0] byte_count;
        out_word_t   pending_results[$];
        int          errors;
        int          words_noted;
        int          results_checked;
        int          endings_seen[6];

        function new();
            break_value     = RST_BREAK_VALUE;
            escape_value    = RST_ESCAPE_VALUE;
            code_for_break  = RST_CODE_FOR_BREAK;
            code_for_escape = RST_CODE_FOR_ESCAPE;
            max_length      = RST_MAX_LENGTH;
            phase           = PH_HUNT;
            escape_pending  = 1'b0;
            byte_count      = '0;
            errors          = 0;
            words_noted     = 0;
            results_checked = 0;
            foreach (endings_seen[i])
                endings_seen[i] = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_BREAK_VALUE:     break_value     = value[7:0];
                CFG_ESCAPE_VALUE:    escape_value    = value[7:0];
                CFG_CODE_FOR_BREAK:  code_for_break  = value[7:0];
                CFG_CODE_FOR_ESCAPE: code_for_escape = value[7:0];
                CFG_MAX_LENGTH:      max_length      = value;
                default: ;
            endcase
        endfunction

        function void end_frame(logic [2:0] status, logic eoi);
            pending_results.push_back({8'h00, byte_count, status, 1'b1});
            escape_pending = 1'b0;
            phase = eoi ? PH_HUNT : PH_SKIP;
        endfunction

        // A byte that would push the count past the capacity ends the frame.
        function void store_byte(logic [7:0] value, logic eoi);
            if (int'(byte_count) + 1 > int'(max_length))
                end_frame(ST_OVERFLOW, eoi);
            else
            begin
                byte_count = byte_count + 16'd1;
                pending_results.push_back({value, byte_count, ST_DATA, 1'b0});
                if (eoi)
                    end_frame(ST_ENDED, 1'b1);
            end
        endfunction

        function void note_link_word(in_word_t word);
            logic [7:0] b;
            logic       eoi;
            b   = word.raw_byte;
            eoi = word.end_of_input;
            words_noted++;
            case (phase)
                PH_SKIP:
                begin
                    if (eoi)
                        phase = PH_HUNT;
                end
                PH_FRAME:
                begin
                    if (escape_pending)
                    begin
                        escape_pending = 1'b0;
                        if (b == code_for_break)
                            store_byte(break_value, eoi);
                        else if (b == code_for_escape)
                            store_byte(escape_value, eoi);
                        else
                            end_frame(ST_BAD_ESC, eoi);
                    end
                    else if (b == break_value)
                        end_frame(ST_CLOSED, eoi);
                    else if (b == escape_value)
                    begin
                        if (eoi)
                            end_frame(ST_TRAIL_ESC, 1'b1);
                        else
                            escape_pending = 1'b1;
                    end
                    else
                        store_byte(b, eoi);
                end
                default:
                begin
                    if (b == break_value)
                    begin
                        phase          = PH_FRAME;
                        escape_pending = 1'b0;
                        byte_count     = '0;
                        if (eoi)
                            end_frame(ST_ENDED, 1'b1);
                    end
                    else
                        phase = PH_HUNT;
                end
            endcase
        endfunction

        function void compare_field(string field, logic [15:0] expected, logic [15:0] actual);
            if (actual !== expected)
            begin
                errors++;
                $error("%s: expected %0d, got %0d", field, expected, actual);
            end
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $error("result word with nothing expected: status %0d", got.status);
                return;
            end
            want = pending_results.pop_front();
            if (want.status <= ST_BAD_ESC)
                endings_seen[want.status]++;
            compare_field("decoded_byte", 16'(want.decoded_byte), 16'(got.decoded_byte));
            compare_field("frame_length", want.frame_length, got.frame_length);
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    in_word_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_word_t              out_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    deframer_scoreboard board;
    bit                 gaps_on;
    int                 hold_offs_asked;
    int                 hold_offs_served;
    int                 link_words_sent;
    int                 settings_applied;
    int                 quiet_cycles;

    byte_stuffing_deframer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                board.note_link_word(in_data);
            if (out_valid && !out_stall)
                board.check_result(out_data);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random stalls, plus a long hold-off whenever one is asked.
    initial
    begin : receiver
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_offs_served != hold_offs_asked)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_offs_served++;
            end
            else
                out_stall <= gaps_on && ($urandom_range(99) < 24);
        end
    end

    task automatic send_word(input in_word_t word);
        in_valid <= 1'b1;
        in_data  <= word;
        link_words_sent++;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        while (gaps_on && $urandom_range(99) < 24)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Sends one received buffer; the last byte carries the end-of-input flag.
    task automatic send_buffer(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            send_word({bytes[i], i == bytes.size() - 1});
    endtask

    // Drops in_valid and waits on the clock first, so the last accepted word is already in the scoreboard.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        board.set_register(index, value);
    endtask

    task automatic apply_settings(input logic [7:0] brk, input logic [7:0] esc,
                                  input logic [7:0] code_brk, input logic [7:0] code_esc,
                                  input logic [15:0] capacity);
        write_register(CFG_BREAK_VALUE, {8'h00, brk});
        write_register(CFG_ESCAPE_VALUE, {8'h00, esc});
        write_register(CFG_CODE_FOR_BREAK, {8'h00, code_brk});
        write_register(CFG_CODE_FOR_ESCAPE, {8'h00, code_esc});
        write_register(CFG_MAX_LENGTH, capacity);
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == board.break_value || b == board.escape_value);
        return b;
    endfunction

    // Mostly a well-formed frame with random content and a random ending;
    // one buffer in ten is plain noise.
    task automatic send_random_buffer();
        logic [7:0] bytes[$];
        logic [7:0] bad_code;
        int         pick;
        int         longest;
        int         payload;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            repeat ($urandom_range(1, 8))
                bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2))
                bytes.push_back(plain_byte());
            bytes.push_back(board.break_value);
            longest = (board.max_length <= 40) ? int'(board.max_length) + 3 : 48;
            payload = ($urandom_range(9) == 0) ? $urandom_range(0, longest)
                                               : $urandom_range(0, 10);
            repeat (payload)
            begin
                pick = $urandom_range(9);
                if (pick == 0)
                begin
                    bytes.push_back(board.escape_value);
                    bytes.push_back(board.code_for_break);
                end
                else if (pick == 1)
                begin
                    bytes.push_back(board.escape_value);
                    bytes.push_back(board.code_for_escape);
                end
                else
                    bytes.push_back(plain_byte());
            end
            pick = $urandom_range(9);
            if (pick < 4)
            begin
                bytes.push_back(board.break_value);
                repeat ($urandom_range(0, 3))
                    bytes.push_back(8'($urandom_range(255)));
            end
            else if (pick == 7)
                bytes.push_back(board.escape_value);
            else if (pick == 8)
            begin
                do
                    bad_code = 8'($urandom_range(255));
                while (bad_code == board.code_for_break || bad_code == board.code_for_escape);
                bytes.push_back(board.escape_value);
                bytes.push_back(bad_code);
                repeat ($urandom_range(0, 3))
                    bytes.push_back(8'($urandom_range(255)));
            end
            else if (pick == 9)
            begin
                repeat ($urandom_range(1, 3))
                    bytes.push_back(8'($urandom_range(255)));
            end
        end
        send_buffer(bytes);
    endtask

    task automatic run_random(input int words);
        int first;
        first = link_words_sent;
        while (link_words_sent - first < words)
            send_random_buffer();
    endtask

    initial
    begin : stimulus
        logic [7:0] bytes[$];
        board            = new();
        gaps_on          = 1'b1;
        hold_offs_asked  = 0;
        link_words_sent  = 0;
        settings_applied = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed buffers at the reset register values.
        bytes = {8'h33};
        send_buffer(bytes);
        bytes = {8'h7E};
        send_buffer(bytes);
        bytes = {8'h7E, 8'hFF, 8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'h00, 8'h7E};
        send_buffer(bytes);
        bytes = {8'h7E, 8'h55, 8'hAA};
        send_buffer(bytes);
        bytes = {8'h7E, 8'h7D};
        send_buffer(bytes);
        bytes = {8'h7E, 8'h7D, 8'h11, 8'h7E, 8'h01};
        send_buffer(bytes);
        wait_drained();

        // Usual values with a small capacity; the receiver holds off meanwhile.
        apply_settings(RST_BREAK_VALUE, RST_ESCAPE_VALUE, RST_CODE_FOR_BREAK,
                       RST_CODE_FOR_ESCAPE, 16'd12);
        hold_offs_asked++;
        run_random(PHASE_WORDS / 2);
        // The sender stops until everything owed has come back.
        wait_drained();
        run_random(PHASE_WORDS / 2);
        wait_drained();

        // No capacity at all: any frame overflows on its first stored byte.
        apply_settings(8'h00, 8'hFF, 8'hFF, 8'h00, 16'h0000);
        bytes = {8'h00, 8'h41, 8'h42};
        send_buffer(bytes);
        run_random(PHASE_WORDS);
        wait_drained();

        // Opposite extremes, full capacity, and a long stretch without gaps.
        gaps_on = 1'b0;
        apply_settings(8'hFF, 8'h00, 8'h00, 8'hFF, 16'hFFFF);
        run_random(PHASE_WORDS);
        wait_drained();
        gaps_on = 1'b1;

        // Break and escape share a value, so the byte always acts as a break.
        apply_settings(8'h55, 8'h55, 8'hAA, 8'h5A, 16'd20);
        bytes = {8'h55, 8'h55};
        send_buffer(bytes);
        run_random(PHASE_WORDS / 2);
        wait_drained();

        // Both codes equal: the pair decodes to the break value.
        apply_settings(RST_BREAK_VALUE, RST_ESCAPE_VALUE, 8'h31, 8'h31, 16'd16);
        run_random(PHASE_WORDS / 2);
        wait_drained();

        repeat (2)
        begin
            apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                           8'($urandom_range(255)), 8'($urandom_range(255)),
                           16'($urandom_range(1, 30)));
            run_random(PHASE_WORDS / 2);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (board.pending_results.size() != 0)
        begin
            board.errors++;
            $error("%0d result words never arrived", board.pending_results.size());
        end
        $display("Run covered %0d link words, %0d result words, %0d register settings.",
                 board.words_noted, board.results_checked, settings_applied);
        $display("Data %0d, closed %0d, ended %0d, overflow %0d,",
                 board.endings_seen[0], board.endings_seen[1], board.endings_seen[2],
                 board.endings_seen[3]);
        $display("trailing escape %0d, bad escape %0d.",
                 board.endings_seen[4], board.endings_seen[5]);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

/* byte_stuffing_deframer.f */
design/bsd_pkg.sv
design/bsd_cfg_regs.sv
design/bsd_decoder.sv
design/bsd_out_queue.sv
design/byte_stuffing_deframer.sv
dv/tb_byte_stuffing_deframer.sv
